/* hw/rtl/naps_pkg.sv */
// ----------------------------------------------------------------------------
// naps_pkg
// Shared constants, result word type and character helpers for the PHTG
// sentence parser.
// ----------------------------------------------------------------------------
package naps_pkg;

   // numeric field range: values must fit a signed VALUE_WIDTH-bit integer
   localparam int VALUE_WIDTH = 32;
   localparam int LATCH_WIDTH = 32;
   localparam int ACC_WIDTH   = VALUE_WIDTH + 4;
   localparam logic [VALUE_WIDTH-1:0] VALUE_LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // line layout
   localparam int LEAD_LEN   = 5;
   localparam int BODY_START = 6;
   localparam int MIN_FIELDS = 6;
   localparam int AUTH_FIELD = 4;
   localparam int WARN_FIELD = 5;

   localparam logic [2:0] POS_MAX   = 3'd7;
   localparam logic [2:0] COUNT_MAX = 3'd6;

   // characters
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // result queue
   localparam int QUEUE_DEPTH = 3;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                           sentence_ok;
      logic signed [LATCH_WIDTH-1:0]  auth_status;
      logic signed [LATCH_WIDTH-1:0]  warning_code;
      logic                           work_state;
      logic                           auth_changed;
   } rsp_type;

   // expected byte of the $PHTG lead-in at a given position
   function automatic logic [7:0] lead_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h50;
         3'd2:    ch = 8'h48;
         3'd3:    ch = 8'h54;
         3'd4:    ch = 8'h47;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // {valid, nibble} for a hex digit character
   function automatic logic [4:0] hex_decode(input logic [7:0] ch);
      logic [4:0] res;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b1, 4'(ch - 8'h30)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         res = {1'b1, 4'(ch - 8'h37)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         res = {1'b1, 4'(ch - 8'h57)};
      end else begin
         res = 5'd0;
      end
      return res;
   endfunction

   // signed VALUE_WIDTH value to the latched width
   function automatic logic [LATCH_WIDTH-1:0] to_latch(input logic [VALUE_WIDTH-1:0] v);
      return LATCH_WIDTH'($signed(v));
   endfunction

endpackage

/* hw/rtl/naps_parser.sv */
// ----------------------------------------------------------------------------
// naps_parser
// Per-byte line state: lead-in check, XOR checksum, field counting and
// signed decimal accumulation. Emits one result word per non-empty line.
// ----------------------------------------------------------------------------
module naps_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_i,
   input  logic [7:0]       byte_i,
   output logic             res_valid_o,
   output naps_pkg::rsp_type res_o
);

   typedef enum logic [1:0] {PH_BODY, PH_DIG1, PH_DIG2, PH_DONE} phase_type;

   logic [2:0]                          pos_ff, pos_in;
   logic                                prefix_ok_ff, prefix_ok_in;
   logic [7:0]                          xor_ff, xor_in;
   logic [2:0]                          fcount_ff, fcount_in;
   phase_type                           phase_ff, phase_in;
   logic [7:0]                          rx_sum_ff, rx_sum_in;
   logic [naps_pkg::VALUE_WIDTH-1:0]    acc_ff, acc_in;
   logic                                seen_ff, seen_in;
   logic                                neg_ff, neg_in;
   logic                                digit_ff, digit_in;
   logic [naps_pkg::LATCH_WIDTH-1:0]    pend_auth_ff, pend_auth_in;
   logic [naps_pkg::LATCH_WIDTH-1:0]    pend_warn_ff, pend_warn_in;
   logic                                line_err_ff, line_err_in;
   logic [naps_pkg::LATCH_WIDTH-1:0]    held_auth_ff, held_auth_in;
   logic [naps_pkg::LATCH_WIDTH-1:0]    held_warn_ff, held_warn_in;

   logic                                is_end;
   logic                                is_digit;
   logic                                num_field;
   logic                                do_close;
   logic                                line_ok;
   logic [4:0]                          hex;
   logic [naps_pkg::ACC_WIDTH-1:0]      acc_next;
   logic [naps_pkg::VALUE_WIDTH-1:0]    signed_val;

   assign is_end    = (byte_i == naps_pkg::CHAR_CR) || (byte_i == naps_pkg::CHAR_LF);
   assign is_digit  = (byte_i >= naps_pkg::CHAR_ZERO) && (byte_i <= naps_pkg::CHAR_NINE);
   assign num_field = (fcount_ff == 3'(naps_pkg::AUTH_FIELD)) ||
                      (fcount_ff == 3'(naps_pkg::WARN_FIELD));
   assign hex       = naps_pkg::hex_decode(byte_i);
   assign acc_next  = naps_pkg::ACC_WIDTH'({acc_ff, 3'b000}) +
                      naps_pkg::ACC_WIDTH'({acc_ff, 1'b0}) +
                      naps_pkg::ACC_WIDTH'(4'(byte_i - naps_pkg::CHAR_ZERO));
   assign signed_val = neg_ff ? (naps_pkg::VALUE_WIDTH'(0) - acc_ff) : acc_ff;
   assign line_ok   = prefix_ok_ff && (pos_ff >= 3'(naps_pkg::LEAD_LEN)) &&
                      (phase_ff == PH_DONE) && !line_err_ff && (rx_sum_ff == xor_ff) &&
                      (fcount_ff >= 3'(naps_pkg::MIN_FIELDS));

   always_comb begin
      pos_in       = pos_ff;
      prefix_ok_in = prefix_ok_ff;
      xor_in       = xor_ff;
      fcount_in    = fcount_ff;
      phase_in     = phase_ff;
      rx_sum_in    = rx_sum_ff;
      acc_in       = acc_ff;
      seen_in      = seen_ff;
      neg_in       = neg_ff;
      digit_in     = digit_ff;
      pend_auth_in = pend_auth_ff;
      pend_warn_in = pend_warn_ff;
      line_err_in  = line_err_ff;
      held_auth_in = held_auth_ff;
      held_warn_in = held_warn_ff;
      do_close     = 1'b0;
      res_valid_o  = 1'b0;
      res_o        = '0;

      if (valid_i) begin
         if (is_end) begin
            if (pos_ff != 3'd0) begin
               if (line_ok) begin
                  held_auth_in = pend_auth_ff;
                  held_warn_in = pend_warn_ff;
               end
               res_valid_o        = 1'b1;
               res_o.sentence_ok  = line_ok;
               res_o.auth_status  = held_auth_in;
               res_o.warning_code = held_warn_in;
               res_o.work_state   = (held_auth_in != '0) &&
                                    !held_auth_in[naps_pkg::LATCH_WIDTH-1];
               res_o.auth_changed = line_ok && (pend_auth_ff != held_auth_ff);
               // start the next line afresh
               pos_in       = 3'd0;
               prefix_ok_in = 1'b1;
               xor_in       = 8'd0;
               fcount_in    = 3'd0;
               phase_in     = PH_BODY;
               rx_sum_in    = 8'd0;
               acc_in       = '0;
               seen_in      = 1'b0;
               neg_in       = 1'b0;
               digit_in     = 1'b0;
               pend_auth_in = '0;
               pend_warn_in = '0;
               line_err_in  = 1'b0;
            end
         end else begin
            if (pos_ff != naps_pkg::POS_MAX) begin
               pos_in = pos_ff + 3'd1;
            end
            if (pos_ff < 3'(naps_pkg::LEAD_LEN) && byte_i != naps_pkg::lead_char(pos_ff)) begin
               prefix_ok_in = 1'b0;
            end

            unique case (phase_ff)
               PH_BODY: begin
                  if (byte_i == naps_pkg::CHAR_STAR) begin
                     do_close = (pos_ff >= 3'(naps_pkg::BODY_START)) && seen_ff;
                     phase_in = PH_DIG1;
                  end else begin
                     if (pos_ff != 3'd0) begin
                        xor_in = xor_ff ^ byte_i;
                     end
                     if (pos_ff >= 3'(naps_pkg::BODY_START)) begin
                        if (byte_i == naps_pkg::CHAR_COMMA) begin
                           do_close = 1'b1;
                        end else begin
                           if (num_field) begin
                              if (is_digit) begin
                                 digit_in = 1'b1;
                                 if (acc_next > naps_pkg::ACC_WIDTH'(naps_pkg::VALUE_LIMIT)) begin
                                    line_err_in = 1'b1;
                                 end else begin
                                    acc_in = acc_next[naps_pkg::VALUE_WIDTH-1:0];
                                 end
                              end else if (!seen_ff && (byte_i == naps_pkg::CHAR_PLUS ||
                                                        byte_i == naps_pkg::CHAR_MINUS)) begin
                                 neg_in = (byte_i == naps_pkg::CHAR_MINUS);
                              end else begin
                                 line_err_in = 1'b1;
                              end
                           end
                           seen_in = 1'b1;
                        end
                     end
                  end
               end
               PH_DIG1: begin
                  line_err_in = line_err_ff | !hex[4];
                  rx_sum_in   = {hex[3:0], 4'h0};
                  phase_in    = PH_DIG2;
               end
               PH_DIG2: begin
                  line_err_in = line_err_ff | !hex[4];
                  rx_sum_in   = (hex[4]) ? {rx_sum_ff[7:4], hex[3:0]} : rx_sum_ff;
                  phase_in    = PH_DONE;
               end
               PH_DONE: begin
               end
               default: begin
               end
            endcase

            if (do_close) begin
               if (num_field && seen_ff) begin
                  if (!digit_ff || (!neg_ff && acc_ff >= naps_pkg::VALUE_LIMIT)) begin
                     line_err_in = 1'b1;
                  end
               end
               if (fcount_ff == 3'(naps_pkg::AUTH_FIELD)) begin
                  pend_auth_in = naps_pkg::to_latch(signed_val);
                  acc_in       = '0;
               end
               if (fcount_ff == 3'(naps_pkg::WARN_FIELD)) begin
                  pend_warn_in = naps_pkg::to_latch(signed_val);
               end
               seen_in  = 1'b0;
               neg_in   = 1'b0;
               digit_in = 1'b0;
               if (fcount_ff != naps_pkg::COUNT_MAX) begin
                  fcount_in = fcount_ff + 3'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         prefix_ok_ff <= 1'b1;
         xor_ff       <= 8'd0;
         fcount_ff    <= 3'd0;
         phase_ff     <= PH_BODY;
         rx_sum_ff    <= 8'd0;
         acc_ff       <= '0;
         seen_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         digit_ff     <= 1'b0;
         pend_auth_ff <= '0;
         pend_warn_ff <= '0;
         line_err_ff  <= 1'b0;
         held_auth_ff <= '0;
         held_warn_ff <= '0;
      end else begin
         pos_ff       <= pos_in;
         prefix_ok_ff <= prefix_ok_in;
         xor_ff       <= xor_in;
         fcount_ff    <= fcount_in;
         phase_ff     <= phase_in;
         rx_sum_ff    <= rx_sum_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         neg_ff       <= neg_in;
         digit_ff     <= digit_in;
         pend_auth_ff <= pend_auth_in;
         pend_warn_ff <= pend_warn_in;
         line_err_ff  <= line_err_in;
         held_auth_ff <= held_auth_in;
         held_warn_ff <= held_warn_in;
      end
   end

endmodule

/* hw/rtl/naps_rsp_queue.sv */
// ----------------------------------------------------------------------------
// naps_rsp_queue
// Small shifting queue of result words; the head slot drives the output.
// ----------------------------------------------------------------------------
module naps_rsp_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push_i,
   input  naps_pkg::rsp_type                  push_data_i,
   input  logic                               pop_i,
   output logic                               valid_o,
   output naps_pkg::rsp_type                  data_o,
   output logic [naps_pkg::QCNT_WIDTH-1:0]    count_o
);

   naps_pkg::rsp_type                    slots_ff [naps_pkg::QUEUE_DEPTH];
   naps_pkg::rsp_type                    slots_in [naps_pkg::QUEUE_DEPTH];
   logic [naps_pkg::QCNT_WIDTH-1:0]      count_ff, count_in;
   logic [naps_pkg::QCNT_WIDTH-1:0]      wr_idx;
   logic                                 do_pop;

   assign do_pop  = pop_i && (count_ff != '0);
   assign wr_idx  = count_ff - naps_pkg::QCNT_WIDTH'(do_pop);
   assign valid_o = (count_ff != '0);
   assign data_o  = slots_ff[0];
   assign count_o = count_ff;
   assign count_in = count_ff + naps_pkg::QCNT_WIDTH'(push_i) - naps_pkg::QCNT_WIDTH'(do_pop);

   always_comb begin
      for (int i = 0; i < naps_pkg::QUEUE_DEPTH; i++) begin
         // advance towards the head on a pop
         if (do_pop && i + 1 < naps_pkg::QUEUE_DEPTH) begin
            slots_in[i] = slots_ff[i+1];
         end else begin
            slots_in[i] = slots_ff[i];
         end
         if (push_i && wr_idx == naps_pkg::QCNT_WIDTH'(i)) begin
            slots_in[i] = push_data_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < naps_pkg::QUEUE_DEPTH; i++) begin
         slots_ff[i] <= slots_in[i];
      end
   end

endmodule

/* hw/rtl/nmea_auth_sentence_parser_core.sv */
// ----------------------------------------------------------------------------
// nmea_auth_sentence_parser_core
// PHTG sentence parser with NMEA XOR checksum, one serial byte per word.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while req_stall is low and gives one
// result word for every non-empty line, once the CR or LF that ends it has
// passed the input register and the per-byte parse step into a three-word
// result queue. A line is accepted when it starts with $PHTG, the two hex
// digits after the first '*' match the XOR of the bytes between '$' and '*',
// fields four and five are well-formed signed decimals and at least six
// fields are present; only then are the authentication result and warning
// code latched. req_stall rises only when the result queue is close to
// full, so input runs at one byte per cycle while results are taken.
module nmea_auth_sentence_parser_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [7:0]                                req_rx_byte,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic                                      rsp_sentence_ok,
   output logic signed [naps_pkg::LATCH_WIDTH-1:0]   rsp_auth_result,
   output logic signed [naps_pkg::LATCH_WIDTH-1:0]   rsp_warning_code,
   output logic                                      rsp_work_state,
   output logic                                      rsp_auth_changed
);

   logic                              in_valid_ff, in_valid_in;
   logic [7:0]                        in_byte_ff, in_byte_in;
   logic                              req_accept;
   logic                              res_valid;
   naps_pkg::rsp_type                 res_word;
   naps_pkg::rsp_type                 head_word;
   logic [naps_pkg::QCNT_WIDTH-1:0]   q_count;
   logic [naps_pkg::QCNT_WIDTH:0]     q_load;

   // hold off once the queue could not take a word from the byte in flight
   assign q_load     = {1'b0, q_count} + (naps_pkg::QCNT_WIDTH+1)'(in_valid_ff);
   assign req_stall  = (q_load >= (naps_pkg::QCNT_WIDTH+1)'(naps_pkg::QUEUE_DEPTH));
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in = req_accept;
   assign in_byte_in  = req_accept ? req_rx_byte : in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   naps_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .valid_i     (in_valid_ff),
      .byte_i      (in_byte_ff),
      .res_valid_o (res_valid),
      .res_o       (res_word)
   );

   naps_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (res_valid),
      .push_data_i (res_word),
      .pop_i       (!rsp_stall),
      .valid_o     (rsp_valid),
      .data_o      (head_word),
      .count_o     (q_count)
   );

   assign rsp_sentence_ok  = head_word.sentence_ok;
   assign rsp_auth_result  = head_word.auth_status;
   assign rsp_warning_code = head_word.warning_code;
   assign rsp_work_state   = head_word.work_state;
   assign rsp_auth_changed = head_word.auth_changed;

endmodule
